// ===== sv/fscbp_pkg.sv =====
// Package with the shared types and constants of the FS command byte parser.
package fscbp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_PRINT_MODE  = 4'd1,
    PH_PAREN       = 4'd2,
    PH_LEN_LO      = 4'd3,
    PH_LEN_HI      = 4'd4,
    PH_RECV        = 4'd5,
    PH_SKIP        = 4'd6,
    PH_UNDERLINE   = 4'd7,
    PH_CODESET     = 4'd8,
    PH_SPACE_LEFT  = 4'd9,
    PH_SPACE_RIGHT = 4'd10,
    PH_QUAD        = 4'd11
  } phase_e;

  // Function bytes that follow FS.
  localparam logic [7:0] FN_PRINT_MODE = 8'h21;
  localparam logic [7:0] FN_KANJI_ON   = 8'h26;
  localparam logic [7:0] FN_PAREN      = 8'h28;
  localparam logic [7:0] FN_UNDERLINE  = 8'h2D;
  localparam logic [7:0] FN_KANJI_OFF  = 8'h2E;
  localparam logic [7:0] FN_CODESET    = 8'h43;
  localparam logic [7:0] FN_SPACING    = 8'h53;
  localparam logic [7:0] FN_QUAD       = 8'h57;
  localparam logic [7:0] SEL_L         = 8'h4C;

  localparam logic [7:0] UL_OFF    = 8'h00;
  localparam logic [7:0] UL_ONE    = 8'h81;
  localparam logic [7:0] UL_TWO    = 8'h83;
  localparam logic [7:0] UL_KEEP   = 8'h0F;
  localparam logic [7:0] ASCII_0   = 8'd48;
  localparam logic [7:0] ASCII_1   = 8'd49;
  localparam logic [7:0] ASCII_2   = 8'd50;
  localparam logic [7:0] SUB_CUT   = 8'd66;
  localparam logic [7:0] SUB_START = 8'd67;

  localparam logic [1:0] FEED_NONE  = 2'd0;
  localparam logic [1:0] FEED_CUT   = 2'd1;
  localparam logic [1:0] FEED_START = 2'd2;

  // Register addresses on the configuration port (word index).
  localparam logic REG_PAGE_SEL = 1'b0;

  typedef struct packed {
    logic       done_res;
    logic       width_double;
    logic       height_double;
    logic [7:0] underline_mode;
    logic       kanji_mode;
    logic [7:0] code_set;
    logic [7:0] left_spacing;
    logic [7:0] right_spacing_std;
    logic [7:0] right_spacing_page;
    logic [1:0] feed_request;
    logic       feed_check_first;
  } fscbp_res_t;

endpackage

// ===== sv/fscbp_in_if.sv =====
// Input channel interface: one command byte per word.
interface fscbp_in_if;
  logic       valid;
  logic       ready;
  logic       begin_req;
  logic [7:0] rx_byte;

  modport source (output valid, output begin_req, output rx_byte, input ready);
  modport sink   (input valid, input begin_req, input rx_byte, output ready);
endinterface

// ===== sv/fscbp_out_if.sv =====
// Output channel interface: settings, done flag and feed request per word.
interface fscbp_out_if;
  logic       valid;
  logic       ready;
  logic       done_res;
  logic       width_double;
  logic       height_double;
  logic [7:0] underline_mode;
  logic       kanji_mode;
  logic [7:0] code_set;
  logic [7:0] left_spacing;
  logic [7:0] right_spacing_std;
  logic [7:0] right_spacing_page;
  logic [1:0] feed_request;
  logic       feed_check_first;

  modport source (output valid, output done_res, output width_double, output height_double,
                  output underline_mode, output kanji_mode, output code_set,
                  output left_spacing, output right_spacing_std, output right_spacing_page,
                  output feed_request, output feed_check_first, input ready);
  modport sink   (input valid, input done_res, input width_double, input height_double,
                  input underline_mode, input kanji_mode, input code_set,
                  input left_spacing, input right_spacing_std, input right_spacing_page,
                  input feed_request, input feed_check_first, output ready);
endinterface

// ===== sv/fscbp_cfg.sv =====
// APB-style configuration register holding the page select flag.
module fscbp_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        page_sel_o
);
  import fscbp_pkg::*;

  logic page_sel_q, page_sel_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PAGE_SEL);

  always_comb begin
    page_sel_d = page_sel_q;
    if (wr_en) begin
      page_sel_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_sel_q <= 1'b0;
    end else begin
      page_sel_q <= page_sel_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAGE_SEL) begin
      prdata = {31'd0, page_sel_q};
    end
  end

  assign page_sel_o = page_sel_q;
endmodule

// ===== sv/fscbp_core.sv =====
// Parse state, settings registers and the per-word next-state logic.
module fscbp_core #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   begin_req_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   page_sel_i,
  output fscbp_pkg::fscbp_res_t  res_o
);
  import fscbp_pkg::*;

  localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  head0_q, head0_d;
  logic        wdbl_q, wdbl_d, hdbl_q, hdbl_d, kanji_q, kanji_d;
  logic [7:0]  ul_q, ul_d, cset_q, cset_d, lsp_q, lsp_d;
  logic [7:0]  rsp_std_q, rsp_std_d, rsp_page_q, rsp_page_d;

  logic        done;
  logic [1:0]  feed;
  logic        check;
  logic [16:0] cnt_inc;
  logic [15:0] len_full;
  logic [7:0]  ul_arg;
  logic        cnt_reached;

  assign cnt_inc     = {1'b0, cnt_q} + 17'd1;
  assign cnt_reached = cnt_inc >= {1'b0, len_q};
  assign len_full    = {rx_byte_i, len_q[7:0]};

  always_comb begin
    if (rx_byte_i >= ASCII_0 && rx_byte_i <= ASCII_2) begin
      ul_arg = rx_byte_i - ASCII_0;
    end else begin
      ul_arg = rx_byte_i;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    head0_d    = head0_q;
    wdbl_d     = wdbl_q;
    hdbl_d     = hdbl_q;
    kanji_d    = kanji_q;
    ul_d       = ul_q;
    cset_d     = cset_q;
    lsp_d      = lsp_q;
    rsp_std_d  = rsp_std_q;
    rsp_page_d = rsp_page_q;
    done       = 1'b0;
    feed       = FEED_NONE;
    check      = 1'b0;

    if (begin_req_i) begin
      phase_d = PH_IDLE;
      case (rx_byte_i)
        FN_PRINT_MODE: phase_d = PH_PRINT_MODE;
        FN_KANJI_ON: begin
          kanji_d = 1'b1;
          done    = 1'b1;
        end
        FN_PAREN:      phase_d = PH_PAREN;
        FN_UNDERLINE:  phase_d = PH_UNDERLINE;
        FN_KANJI_OFF: begin
          kanji_d = 1'b0;
          done    = 1'b1;
        end
        FN_CODESET:    phase_d = PH_CODESET;
        FN_SPACING:    phase_d = PH_SPACE_LEFT;
        FN_QUAD:       phase_d = PH_QUAD;
        default:       done = 1'b1;
      endcase
    end else begin
      case (phase_q)
        PH_PRINT_MODE: begin
          wdbl_d = rx_byte_i[2];
          hdbl_d = rx_byte_i[3];
          ul_d   = rx_byte_i[7] ? (ul_q | UL_ONE) : (ul_q & UL_KEEP);
          done   = 1'b1;
        end
        PH_PAREN: begin
          if (rx_byte_i == SEL_L) begin
            phase_d = PH_LEN_LO;
          end else begin
            done = 1'b1;
          end
        end
        PH_LEN_LO: begin
          len_d   = {8'd0, rx_byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d = len_full;
          cnt_d = '0;
          if (len_full == 16'd0) begin
            done = 1'b1;
          end else if ({1'b0, len_full} > BufLimit) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_RECV;
          end
        end
        PH_RECV: begin
          if (cnt_q == 16'd0) begin
            head0_d = rx_byte_i;
          end
          cnt_d = cnt_inc[15:0];
          if (cnt_reached) begin
            // A two-byte payload completes on its second byte, which is rx_byte_i.
            if (len_q == 16'd2 &&
                (head0_q == SUB_CUT || head0_q == SUB_START) &&
                (rx_byte_i == ASCII_0 || rx_byte_i == ASCII_1)) begin
              feed  = (head0_q == SUB_CUT) ? FEED_CUT : FEED_START;
              check = (rx_byte_i == ASCII_0);
            end
            done = 1'b1;
          end
        end
        PH_SKIP: begin
          cnt_d = cnt_inc[15:0];
          if (cnt_reached) begin
            done = 1'b1;
          end
        end
        PH_UNDERLINE: begin
          case (ul_arg)
            8'd0:    ul_d = UL_OFF;
            8'd1:    ul_d = UL_ONE;
            8'd2:    ul_d = UL_TWO;
            default: ul_d = ul_q;
          endcase
          done = 1'b1;
        end
        PH_CODESET: begin
          if (rx_byte_i inside {8'd0, 8'd1, 8'd11, 8'd12, 8'd21, 8'd128}) begin
            cset_d = rx_byte_i;
          end
          done = 1'b1;
        end
        PH_SPACE_LEFT: begin
          lsp_d   = rx_byte_i;
          phase_d = PH_SPACE_RIGHT;
        end
        PH_SPACE_RIGHT: begin
          if (page_sel_i) begin
            rsp_page_d = rx_byte_i;
          end else begin
            rsp_std_d = rx_byte_i;
          end
          done = 1'b1;
        end
        PH_QUAD: begin
          wdbl_d = rx_byte_i[0];
          hdbl_d = rx_byte_i[0];
          done   = 1'b1;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    if (done) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      len_q      <= '0;
      cnt_q      <= '0;
      wdbl_q     <= 1'b0;
      hdbl_q     <= 1'b0;
      kanji_q    <= 1'b0;
      ul_q       <= '0;
      cset_q     <= '0;
      lsp_q      <= '0;
      rsp_std_q  <= '0;
      rsp_page_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      wdbl_q     <= wdbl_d;
      hdbl_q     <= hdbl_d;
      kanji_q    <= kanji_d;
      ul_q       <= ul_d;
      cset_q     <= cset_d;
      lsp_q      <= lsp_d;
      rsp_std_q  <= rsp_std_d;
      rsp_page_q <= rsp_page_d;
    end
  end

  // The first payload byte needs no reset; it is always written before it is read.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      head0_q <= head0_d;
    end
  end

  always_comb begin
    res_o.done_res           = done;
    res_o.width_double       = wdbl_d;
    res_o.height_double      = hdbl_d;
    res_o.underline_mode     = ul_d;
    res_o.kanji_mode         = kanji_d;
    res_o.code_set           = cset_d;
    res_o.left_spacing       = lsp_d;
    res_o.right_spacing_std  = rsp_std_d;
    res_o.right_spacing_page = rsp_page_d;
    res_o.feed_request       = feed;
    res_o.feed_check_first   = check;
  end
endmodule

// ===== sv/fs_command_byte_parser_unit.sv =====
// Top level of the FS command byte parser: input register, parser core, result register.
//
// Feed the bytes that follow an FS prefix into in_i, one word per byte, with
// begin_req set on the function byte right after FS. Every accepted word gives
// exactly one result word on out_o: the Kanji settings after that byte, a done
// flag that marks the end of the FS sequence, and a feed request for a
// completed FS ( L subcommand 66 or 67.
// A word waits in the input register, and the parse step then writes its result
// into the result register. Throughput is one word per cycle while out_o takes
// results; the parse state is updated in the same cycle that a word leaves the
// input register, so consecutive bytes follow back to back.
// When out_o stalls, the result register holds its word, the input register
// holds one more, and in_i.ready falls until the result is taken.
// Reset clears the parse phase, the length counters and all settings, and
// empties both registers. The page select register at byte address 0 of the
// APB port picks which right spacing slot FS S writes; write it only while
// no word is in flight.
module fs_command_byte_parser_unit #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fscbp_in_if.sink           in_i,
  fscbp_out_if.source        out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fscbp_pkg::*;

  logic       in_vld_q;
  logic       in_begin_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  fscbp_res_t res_q;
  fscbp_res_t res_d;
  logic       page_sel;
  logic       out_free;
  logic       step;

  assign out_free  = !out_vld_q || out_o.ready;
  assign step      = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  fscbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .page_sel_o (page_sel)
  );

  fscbp_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .begin_req_i (in_begin_q),
    .rx_byte_i   (in_byte_q),
    .page_sel_i  (page_sel),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_free) begin
        out_vld_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_begin_q <= in_i.begin_req;
      in_byte_q  <= in_i.rx_byte;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.done_res           = res_q.done_res;
  assign out_o.width_double       = res_q.width_double;
  assign out_o.height_double      = res_q.height_double;
  assign out_o.underline_mode     = res_q.underline_mode;
  assign out_o.kanji_mode         = res_q.kanji_mode;
  assign out_o.code_set           = res_q.code_set;
  assign out_o.left_spacing       = res_q.left_spacing;
  assign out_o.right_spacing_std  = res_q.right_spacing_std;
  assign out_o.right_spacing_page = res_q.right_spacing_page;
  assign out_o.feed_request       = res_q.feed_request;
  assign out_o.feed_check_first   = res_q.feed_check_first;
endmodule

// ===== test/tb_fs_command_byte_parser_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the FS command byte parser: directed and random byte streams checked word by word.
module tb_fs_command_byte_parser_unit;
  import fscbp_pkg::*;

  localparam int unsigned BUFFER_BYTES = 256;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned FEED_PAYLOAD_LEN = 2;
  localparam logic [7:0] UL_ARG_OFF = 8'd0;
  localparam logic [7:0] UL_ARG_ONE = 8'd1;
  localparam logic [7:0] UL_ARG_TWO = 8'd2;
  localparam logic [7:0] KNOWN_CODE_SETS [6] = '{8'd0, 8'd1, 8'd11, 8'd12, 8'd21, 8'd128};

  // One input word: begin_req in the top bit, the byte below it.
  typedef logic [8:0] fs_word_t;
  typedef fs_word_t fs_seq_t[$];

  class fs_settings_tracker;
    phase_e      phase;
    logic [15:0] pay_len;
    logic [15:0] pay_cnt;
    logic [7:0]  pay_head [2];
    logic        page_sel;
    fscbp_res_t  settings;
    fscbp_res_t  pending_words [$];
    int unsigned mismatches;

    function new();
      phase = PH_IDLE;
      pay_len = '0;
      pay_cnt = '0;
      pay_head = '{default: '0};
      page_sel = 1'b0;
      settings = '0;
      mismatches = 0;
    endfunction

    function void note_byte(logic begin_req, logic [7:0] b);
      fscbp_res_t want;
      logic       done;
      logic [1:0] feed;
      logic       check;
      logic [7:0] arg;
      done = 1'b0;
      feed = FEED_NONE;
      check = 1'b0;
      if (begin_req) begin
        // A function byte always restarts the parse, whatever was in progress.
        phase = PH_IDLE;
        case (b)
          FN_PRINT_MODE: phase = PH_PRINT_MODE;
          FN_KANJI_ON: begin
            settings.kanji_mode = 1'b1;
            done = 1'b1;
          end
          FN_PAREN: phase = PH_PAREN;
          FN_UNDERLINE: phase = PH_UNDERLINE;
          FN_KANJI_OFF: begin
            settings.kanji_mode = 1'b0;
            done = 1'b1;
          end
          FN_CODESET: phase = PH_CODESET;
          FN_SPACING: phase = PH_SPACE_LEFT;
          FN_QUAD: phase = PH_QUAD;
          default: done = 1'b1;
        endcase
      end else begin
        case (phase)
          PH_PRINT_MODE: begin
            settings.width_double = b[2];
            settings.height_double = b[3];
            settings.underline_mode = b[7] ? (settings.underline_mode | UL_ONE)
                                           : (settings.underline_mode & UL_KEEP);
            done = 1'b1;
          end
          PH_PAREN: begin
            if (b == SEL_L) phase = PH_LEN_LO;
            else done = 1'b1;
          end
          PH_LEN_LO: begin
            pay_len = {8'h00, b};
            phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            pay_len[15:8] = b;
            pay_cnt = '0;
            if (pay_len == '0) done = 1'b1;
            else if (pay_len > BUFFER_BYTES) phase = PH_SKIP;
            else phase = PH_RECV;
          end
          PH_RECV: begin
            if (pay_cnt < FEED_PAYLOAD_LEN) pay_head[pay_cnt[0]] = b;
            pay_cnt = pay_cnt + 1'b1;
            if (pay_cnt >= pay_len) begin
              if (pay_len == FEED_PAYLOAD_LEN &&
                  (pay_head[0] == SUB_CUT || pay_head[0] == SUB_START) &&
                  (pay_head[1] == ASCII_0 || pay_head[1] == ASCII_1)) begin
                feed = (pay_head[0] == SUB_CUT) ? FEED_CUT : FEED_START;
                check = (pay_head[1] == ASCII_0);
              end
              done = 1'b1;
            end
          end
          PH_SKIP: begin
            pay_cnt = pay_cnt + 1'b1;
            if (pay_cnt >= pay_len) done = 1'b1;
          end
          PH_UNDERLINE: begin
            arg = (b >= ASCII_0 && b <= ASCII_2) ? b - ASCII_0 : b;
            case (arg)
              UL_ARG_OFF: settings.underline_mode = UL_OFF;
              UL_ARG_ONE: settings.underline_mode = UL_ONE;
              UL_ARG_TWO: settings.underline_mode = UL_TWO;
              default: ;
            endcase
            done = 1'b1;
          end
          PH_CODESET: begin
            foreach (KNOWN_CODE_SETS[i]) begin
              if (b == KNOWN_CODE_SETS[i]) settings.code_set = b;
            end
            done = 1'b1;
          end
          PH_SPACE_LEFT: begin
            settings.left_spacing = b;
            phase = PH_SPACE_RIGHT;
          end
          PH_SPACE_RIGHT: begin
            if (page_sel) settings.right_spacing_page = b;
            else settings.right_spacing_std = b;
            done = 1'b1;
          end
          PH_QUAD: begin
            settings.width_double = b[0];
            settings.height_double = b[0];
            done = 1'b1;
          end
          default: phase = PH_IDLE;
        endcase
      end
      if (done) phase = PH_IDLE;
      want = settings;
      want.done_res = done;
      want.feed_request = feed;
      want.feed_check_first = check;
      pending_words.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want_v, logic [7:0] seen_v);
      if (want_v !== seen_v) begin
        $error("%s: expected %0h, got %0h", field, want_v, seen_v);
        mismatches++;
      end
    endfunction

    function void check_word(fscbp_res_t seen);
      fscbp_res_t want;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: %h", seen);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      compare("done_res", want.done_res, seen.done_res);
      compare("width_double", want.width_double, seen.width_double);
      compare("height_double", want.height_double, seen.height_double);
      compare("underline_mode", want.underline_mode, seen.underline_mode);
      compare("kanji_mode", want.kanji_mode, seen.kanji_mode);
      compare("code_set", want.code_set, seen.code_set);
      compare("left_spacing", want.left_spacing, seen.left_spacing);
      compare("right_spacing_std", want.right_spacing_std, seen.right_spacing_std);
      compare("right_spacing_page", want.right_spacing_page, seen.right_spacing_page);
      compare("feed_request", want.feed_request, seen.feed_request);
      compare("feed_check_first", want.feed_check_first, seen.feed_check_first);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fscbp_in_if  in_if ();
  fscbp_out_if out_if ();

  fs_settings_tracker tracker = new();

  bit          quiet;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned seq_words;

  fs_command_byte_parser_unit #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fs_command_byte_parser_unit verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls of mostly short length.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Both sides are sampled at the edge, before any driver update lands.
  always @(posedge clk_i) begin
    fscbp_res_t seen;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) tracker.note_byte(in_if.begin_req, in_if.rx_byte);
      if (out_if.valid && out_if.ready) begin
        seen.done_res = out_if.done_res;
        seen.width_double = out_if.width_double;
        seen.height_double = out_if.height_double;
        seen.underline_mode = out_if.underline_mode;
        seen.kanji_mode = out_if.kanji_mode;
        seen.code_set = out_if.code_set;
        seen.left_spacing = out_if.left_spacing;
        seen.right_spacing_std = out_if.right_spacing_std;
        seen.right_spacing_page = out_if.right_spacing_page;
        seen.feed_request = out_if.feed_request;
        seen.feed_check_first = out_if.feed_check_first;
        tracker.check_word(seen);
      end
    end
  end

  task automatic push_byte(input logic begin_req, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.begin_req <= begin_req;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_bytes(input fs_seq_t s);
    foreach (s[i]) push_byte(s[i][8], s[i][7:0]);
  endtask

  // Holds the input until every expected word is back, then writes page_sel.
  task automatic set_page_sel(input logic mode);
    in_if.valid <= 1'b0;
    // Waiting for this edge lets the monitor note the last word that was accepted.
    @(posedge clk_i);
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_PAGE_SEL, 2'b00};
    pwdata <= {31'd0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.page_sel = mode;
  endtask

  function automatic fs_seq_t make_sequence();
    fs_seq_t     s;
    int unsigned kind;
    int unsigned roll;
    logic [15:0] len;
    logic [7:0]  b;
    kind = $urandom_range(0, 17);
    case (kind)
      0, 1: s = '{{1'b1, FN_PRINT_MODE}, {1'b0, 8'($urandom)}};
      2: s = '{{1'b1, FN_KANJI_ON}};
      3: s = '{{1'b1, FN_KANJI_OFF}};
      4, 5: begin
        roll = $urandom_range(0, 6);
        if (roll < 3) b = 8'(roll);
        else if (roll < 6) b = ASCII_0 + 8'(roll - 3);
        else b = 8'($urandom);
        s = '{{1'b1, FN_UNDERLINE}, {1'b0, b}};
      end
      6, 7: begin
        b = ($urandom_range(0, 9) < 7) ? KNOWN_CODE_SETS[$urandom_range(0, 5)]
                                       : 8'($urandom);
        s = '{{1'b1, FN_CODESET}, {1'b0, b}};
      end
      8, 9: s = '{{1'b1, FN_SPACING}, {1'b0, 8'($urandom)}, {1'b0, 8'($urandom)}};
      10: s = '{{1'b1, FN_QUAD}, {1'b0, 8'($urandom)}};
      11: s = '{{1'b1, 8'($urandom)}};
      default: begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SEL_L;
        s = '{{1'b1, FN_PAREN}, {1'b0, b}};
        roll = $urandom_range(0, 19);
        if (roll < 12) len = 16'(FEED_PAYLOAD_LEN);
        else if (roll < 14) len = '0;
        else if (roll < 19) len = 16'($urandom_range(1, 8));
        else len = 16'($urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + 300));
        s.push_back({1'b0, len[7:0]});
        s.push_back({1'b0, len[15:8]});
        for (int i = 0; i < len; i++) begin
          if (i == 0 && $urandom_range(0, 4) != 0)
            b = $urandom_range(0, 1) ? SUB_CUT : SUB_START;
          else if (i == 1 && $urandom_range(0, 4) != 0)
            b = $urandom_range(0, 1) ? ASCII_0 : ASCII_1;
          else
            b = 8'($urandom);
          s.push_back({1'b0, b});
        end
      end
    endcase
    // Some sequences are cut short; the next function byte abandons them.
    if (s.size() > 1 && $urandom_range(0, 9) == 0) s = s[0:$urandom_range(0, s.size() - 2)];
    return s;
  endfunction

  initial begin
    fs_seq_t s;
    in_if.valid <= 1'b0;
    in_if.begin_req <= 1'b0;
    in_if.rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_bytes('{
      {1'b0, 8'h00},
      {1'b1, FN_KANJI_ON},
      {1'b1, FN_PRINT_MODE}, {1'b0, 8'hFF},
      {1'b1, FN_UNDERLINE}, {1'b0, ASCII_2},
      {1'b1, FN_PRINT_MODE}, {1'b0, 8'h00},
      {1'b1, FN_CODESET}, {1'b0, KNOWN_CODE_SETS[5]},
      {1'b1, FN_SPACING}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
      {1'b1, FN_QUAD}, {1'b0, 8'h01},
      {1'b1, FN_PAREN}, {1'b0, SEL_L}, {1'b0, 8'h02}, {1'b0, 8'h00},
      {1'b0, SUB_START}, {1'b0, ASCII_1},
      {1'b1, FN_PAREN}, {1'b1, FN_KANJI_OFF},
      {1'b1, 8'hFF}
    });
    set_page_sel(1'b1);
    send_bytes('{{1'b1, FN_SPACING}, {1'b0, 8'h00}, {1'b0, 8'h7F}});

    for (int p = 0; p < 4; p++) begin
      set_page_sel(p[0]);
      quiet = (p == 2);
      while (seq_words < (p + 1) * RANDOM_WORDS / 4) begin
        if ($urandom_range(0, 19) == 0) begin
          push_byte(1'b0, 8'($urandom));
        end else begin
          s = make_sequence();
          send_bytes(s);
          seq_words += s.size();
        end
      end
    end

    // Shortest payload that is skipped, sent without idling.
    quiet = 1'b1;
    s = '{{1'b1, FN_PAREN}, {1'b0, SEL_L}, {1'b0, 8'h01}, {1'b0, 8'h01}};
    repeat (BUFFER_BYTES + 1) s.push_back({1'b0, 8'($urandom)});
    send_bytes(s);
    quiet = 1'b0;
    send_bytes('{{1'b1, FN_KANJI_ON}});

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("fs_command_byte_parser_unit verification clean");
    end else begin
      $display("fs_command_byte_parser_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== fs_command_byte_parser_unit.f =====
sv/fscbp_pkg.sv
sv/fscbp_in_if.sv
sv/fscbp_out_if.sv
sv/fscbp_cfg.sv
sv/fscbp_core.sv
sv/fs_command_byte_parser_unit.sv
test/tb_fs_command_byte_parser_unit.sv
